@@ hdl/bsmc_pkg.sv @@
package bsmc_pkg;

  // store geometry
  localparam int BLOCK_COUNT = 256;
  localparam int ROM_BANKS   = 16;
  localparam int OFF_W       = 14;
  localparam int BLK_W       = $clog2(BLOCK_COUNT);
  localparam int IDX_W       = BLK_W + OFF_W;
  localparam int WORDS       = BLOCK_COUNT * (1 << OFF_W);

  // command queue
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  // config register indexes
  localparam logic [1:0] CFG_MACHINE = 2'd0;
  localparam logic [1:0] CFG_MASK    = 2'd1;
  localparam logic [1:0] CFG_BANK    = 2'd2;

  localparam logic REQ_READ  = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  localparam logic [4:0] BANK_RESET     = 5'd16;
  localparam logic [7:0] PAGE_RESET     = 8'hff;
  localparam logic [8:0] ROM_BLOCK_BASE = 9'h010;

  localparam logic [15:0] ROM_LO        = 16'h8000;
  localparam logic [15:0] ROM_HI        = 16'hc000;
  localparam logic [15:0] IO_LO         = 16'hfc00;
  localparam logic [15:0] HI_LO         = 16'hff00;
  localparam logic [15:0] VEC_LO        = 16'hfff0;
  localparam logic [15:0] MMU_ON_ADDR   = 16'hfe0e;
  localparam logic [15:0] MMU_OFF_ADDR  = 16'hfe0f;
  localparam logic [15:0] MMU_PAGE_ADDR = 16'hfe10;
  localparam logic [15:0] MMU_PAGE_LAST = 16'hfe13;
  localparam logic [15:0] ROM_LATCH_ADDR = 16'hfe30;

  typedef enum logic [1:0] {
    MK_FLAT    = 2'd0,
    MK_FLAT_HI = 2'd1,
    MK_SWROM   = 2'd2,
    MK_MMU     = 2'd3
  } machine_t;

  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2
  } op_t;

  typedef struct packed {
    op_t              op;
    logic             checked;
    logic [IDX_W-1:0] idx;
    logic [7:0]       data;
    logic             rnw_error;
    logic             write_ignored;
  } cmd_t;

  typedef struct packed {
    logic          full;
    logic          empty;
    logic [Q_AW:0] count;
  } q_status_t;

  typedef struct packed {
    logic       rnw_error;
    logic       data_mismatch;
    logic [7:0] expected_data;
    logic       write_ignored;
  } res_t;

  // block used for each 16K window while the MMU is off
  function automatic logic [7:0] mmu_off_block(input logic [1:0] win);
    logic [7:0] blk;
    case (win)
      2'd0:    blk = 8'h80;
      2'd1:    blk = 8'h81;
      2'd2:    blk = 8'h00;
      default: blk = 8'h01;
    endcase
    return blk;
  endfunction

endpackage

@@ hdl/bsmc_front.sv @@
module bsmc_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  logic            req_type,
  input  logic            address_known,
  input  logic [15:0]     address,
  input  logic [7:0]      bus_data,
  input  logic            rnw_pin,
  input  logic [2:0]      access_type,
  input  logic            cfg_wr_en,
  input  logic [1:0]      cfg_index,
  input  logic [7:0]      cfg_data,
  output bsmc_pkg::cmd_t  cmd
);
  import bsmc_pkg::*;

  machine_t   machine_kind;
  logic [7:0] model_mask;
  logic [4:0] rom_bank;
  logic       mmu_on;
  logic [7:0] mmu_page [4];

  logic       en;
  logic       in_io;
  logic       in_rom;
  logic [8:0] blk;
  logic       loc_ok;
  logic       set_bank;
  logic       set_mmu_on;
  logic       set_mmu_off;
  logic       page_we;

  always_ff @(posedge clk) begin
    if (rst) begin
      machine_kind <= MK_FLAT;
      model_mask   <= '0;
      rom_bank     <= BANK_RESET;
      mmu_on       <= 1'b0;
      for (int i = 0; i < 4; i++) mmu_page[i] <= PAGE_RESET;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_MACHINE: machine_kind <= machine_t'(cfg_data[1:0]);
          CFG_MASK:    model_mask   <= cfg_data;
          CFG_BANK:    rom_bank     <= cfg_data[4:0];
          default: ;
        endcase
      end
      if (accept) begin
        if (set_bank)    rom_bank <= {1'b0, bus_data[3:0]};
        if (set_mmu_on)  mmu_on   <= 1'b1;
        if (set_mmu_off) mmu_on   <= 1'b0;
        if (page_we)     mmu_page[address[1:0]] <= bus_data;
      end
    end
  end

  always_comb begin
    en     = address_known && model_mask[access_type];
    in_io  = (address >= IO_LO) && (address < HI_LO);
    in_rom = (address >= ROM_LO) && (address < ROM_HI);

    // map the address onto a 16K block of the store
    loc_ok = 1'b1;
    case (machine_kind)
      MK_MMU: begin
        blk = {1'b0, mmu_on ? mmu_page[address[15:14]] : mmu_off_block(address[15:14])};
      end
      MK_SWROM: begin
        if (in_rom) begin
          blk    = ROM_BLOCK_BASE + {4'b0, rom_bank};
          loc_ok = rom_bank < 5'(ROM_BANKS);
        end else begin
          blk = {7'b0, address[15:14]};
        end
      end
      default: blk = {7'b0, address[15:14]};
    endcase
    if (blk >= 9'(BLOCK_COUNT)) loc_ok = 1'b0;

    set_bank    = 1'b0;
    set_mmu_on  = 1'b0;
    set_mmu_off = 1'b0;
    page_we     = 1'b0;

    cmd.op            = OP_NONE;
    cmd.checked       = 1'b1;
    cmd.idx           = {blk[BLK_W-1:0], address[OFF_W-1:0]};
    cmd.data          = bus_data;
    cmd.rnw_error     = (req_type == REQ_WRITE) ? rnw_pin : !rnw_pin;
    cmd.write_ignored = 1'b0;

    if (en) begin
      if (req_type == REQ_WRITE) begin
        if (machine_kind == MK_MMU && in_io) begin
          set_mmu_on  = (address == MMU_ON_ADDR) && bus_data[4];
          set_mmu_off = (address == MMU_OFF_ADDR) && bus_data[4];
          page_we     = (address >= MMU_PAGE_ADDR) && (address <= MMU_PAGE_LAST);
        end else begin
          if (machine_kind == MK_SWROM) begin
            set_bank = address == ROM_LATCH_ADDR;
            cmd.write_ignored = ((address >= ROM_LO) && (address < IO_LO)) ||
                                (address >= HI_LO);
          end
          if (!cmd.write_ignored && loc_ok) cmd.op = OP_WRITE;
        end
      end else begin
        // I/O reads on the larger machines are not tracked
        if (!((machine_kind == MK_SWROM || machine_kind == MK_MMU) && in_io)) begin
          cmd.checked = !(machine_kind == MK_FLAT_HI && address >= HI_LO &&
                          address < VEC_LO);
          if (loc_ok) cmd.op = OP_READ;
        end
      end
    end
  end

endmodule

@@ hdl/bsmc_queue.sv @@
module bsmc_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  bsmc_pkg::cmd_t      wr_cmd,
  input  logic                pop,
  output bsmc_pkg::cmd_t      rd_cmd,
  output bsmc_pkg::q_status_t status
);
  import bsmc_pkg::*;

  cmd_t          slots [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr;
  logic [Q_AW-1:0] rd_ptr;
  logic [Q_AW:0]   count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= wr_cmd;
  end

  assign rd_cmd       = slots[rd_ptr];
  assign status.full  = count == (Q_AW+1)'(Q_DEPTH);
  assign status.empty = count == '0;
  assign status.count = count;

endmodule

@@ hdl/bsmc_back.sv @@
module bsmc_back (
  input  logic                clk,
  input  logic                rst,
  input  bsmc_pkg::q_status_t q_status,
  input  bsmc_pkg::cmd_t      head,
  output logic                pop,
  input  logic                out_ready,
  output logic                out_valid,
  output bsmc_pkg::res_t      result,
  output logic                clearing
);
  import bsmc_pkg::*;

  // {known, byte}
  logic [8:0] mem [WORDS];
  logic [8:0] rd_q;

  logic [IDX_W-1:0] clr_addr;

  logic       s1_valid;
  cmd_t       s1;
  logic       hit;
  logic [8:0] hit_word;

  logic             s1_done;
  logic [IDX_W-1:0] rd_addr;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [8:0]       wr_word;
  logic [8:0]       word;
  logic             mis;

  always_comb begin
    s1_done = s1_valid && (!out_valid || out_ready);
    pop     = !clearing && !q_status.empty && (!s1_valid || s1_done);
    // a stalled word re-reads its own address
    rd_addr = pop ? head.idx : s1.idx;

    case (s1.op)
      OP_READ, OP_WRITE: wr_en = s1_done;
      default:           wr_en = 1'b0;
    endcase
    wr_addr = s1.idx;
    wr_word = {1'b1, s1.data};
    if (clearing) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr;
      wr_word = '0;
    end

    // same-cycle write to the address being read
    word = hit ? hit_word : rd_q;
    mis  = (s1.op == OP_READ) && s1.checked && word[8] && (word[7:0] != s1.data);
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_word;
    rd_q     <= mem[rd_addr];
    hit      <= wr_en && (wr_addr == rd_addr);
    hit_word <= wr_word;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing  <= 1'b1;
      clr_addr  <= '0;
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (clearing) begin
        clr_addr <= clr_addr + 1'b1;
        if (clr_addr == IDX_W'(WORDS - 1)) clearing <= 1'b0;
      end
      if (pop)          s1_valid <= 1'b1;
      else if (s1_done) s1_valid <= 1'b0;
      if (s1_done)        out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) s1 <= head;
    if (s1_done) begin
      result.rnw_error     <= s1.rnw_error;
      result.data_mismatch <= mis;
      result.expected_data <= mis ? word[7:0] : 8'h00;
      result.write_ignored <= s1.write_ignored;
    end
  end

endmodule

@@ hdl/bus_shadow_memory_checker_top.sv @@
// An accepted word is held in a queue slot, then in s1, then in the result register.
// Throughput: one word per cycle when out_ready does not hold results back, set by the
// single read-modify-write port of the shadow memory (same-cycle write/read forwarded);
// a four-deep queue decouples decode. Reset: control state clears, then the shadow memory
// is swept to unknown one word a cycle, with in_ready low; config writes still land.
module bus_shadow_memory_checker_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        req_type,
  input  logic        address_known,
  input  logic [15:0] address,
  input  logic [7:0]  bus_data,
  input  logic        rnw_pin,
  input  logic [2:0]  access_type,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        rnw_error,
  output logic        data_mismatch,
  output logic [7:0]  expected_data,
  output logic        write_ignored,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  import bsmc_pkg::*;

  cmd_t      front_cmd;
  cmd_t      head;
  q_status_t qs;
  res_t      result;
  logic      accept;
  logic      pop;
  logic      clearing;

  assign in_ready = !qs.full && !clearing;
  assign accept   = in_valid && in_ready;

  bsmc_front u_front (
    .clk, .rst, .accept,
    .req_type, .address_known, .address, .bus_data, .rnw_pin, .access_type,
    .cfg_wr_en, .cfg_index, .cfg_data,
    .cmd (front_cmd)
  );

  bsmc_queue u_queue (
    .clk, .rst,
    .push   (accept),
    .wr_cmd (front_cmd),
    .pop,
    .rd_cmd (head),
    .status (qs)
  );

  bsmc_back u_back (
    .clk, .rst,
    .q_status (qs),
    .head,
    .pop,
    .out_ready,
    .out_valid,
    .result,
    .clearing
  );

  assign rnw_error     = result.rnw_error;
  assign data_mismatch = result.data_mismatch;
  assign expected_data = result.expected_data;
  assign write_ignored = result.write_ignored;

  a_no_result_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !out_valid)
    else $error("result presented during memory clear");

  a_expected_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !data_mismatch |-> expected_data == 8'h00)
    else $error("expected_data set without a mismatch");

  a_ignore_excl_mismatch: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(data_mismatch && write_ignored))
    else $error("mismatch and ignored write on one word");

  a_push_lands: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !qs.empty)
    else $error("accepted word missing from queue");

endmodule

@@ tb/bsmc_shadow_checker.sv @@
`timescale 1ns / 100ps
module bsmc_shadow_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        req_type,
  input  logic        address_known,
  input  logic [15:0] address,
  input  logic [7:0]  bus_data,
  input  logic        rnw_pin,
  input  logic [2:0]  access_type,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        rnw_error,
  input  logic        data_mismatch,
  input  logic [7:0]  expected_data,
  input  logic        write_ignored,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  output int          errors,
  output int          pending
);
  import bsmc_pkg::*;

  // store block per 16K window while the MMU is disabled
  localparam logic [7:0] WIN_BLOCK_MMU_OFF [4] = '{8'h80, 8'h81, 8'h00, 8'h01};

  machine_t   mode;
  logic [7:0] type_mask;
  logic [4:0] bank_latch;
  logic       mmu_en;
  logic [7:0] mmu_map [4];
  logic [7:0] shadow_mem [int];   // entry present means the word is known
  res_t       result_q [$];

  // word index in the shadow store, -1 when the access is not backed by it
  function automatic int shadow_index(input logic [15:0] ea);
    int blk;
    if (mode == MK_MMU) begin
      blk = mmu_en ? mmu_map[ea[15:14]] : WIN_BLOCK_MMU_OFF[ea[15:14]];
    end else if (mode == MK_SWROM && ea >= ROM_LO && ea < ROM_HI) begin
      if (bank_latch >= ROM_BANKS) return -1;
      blk = ROM_BLOCK_BASE + bank_latch;
    end else begin
      blk = ea[15:14];
    end
    if (blk >= BLOCK_COUNT) return -1;
    return blk * (1 << OFF_W) + ea[13:0];
  endfunction

  function automatic res_t predict_access(input logic wr, input logic known,
                                          input logic [15:0] ea, input logic [7:0] data,
                                          input logic pin, input logic [2:0] kind);
    res_t r;
    int   idx;
    r = '0;
    r.rnw_error = (wr == REQ_WRITE) ? pin : !pin;
    if (!known || !type_mask[kind]) return r;
    if (wr == REQ_WRITE) begin
      if (mode == MK_MMU && ea >= IO_LO && ea < HI_LO) begin
        if (ea == MMU_ON_ADDR) begin
          if (data[4]) mmu_en = 1'b1;
        end else if (ea == MMU_OFF_ADDR) begin
          if (data[4]) mmu_en = 1'b0;
        end else if (ea >= MMU_PAGE_ADDR && ea <= MMU_PAGE_LAST) begin
          mmu_map[ea[1:0]] = data;
        end
        return r;
      end
      if (mode == MK_SWROM) begin
        // the latch write still lands in the flat I/O area of the store
        if (ea == ROM_LATCH_ADDR) bank_latch = {1'b0, data[3:0]};
        if ((ea >= ROM_LO && ea < IO_LO) || ea >= HI_LO) begin
          r.write_ignored = 1'b1;
          return r;
        end
      end
      idx = shadow_index(ea);
      if (idx >= 0) shadow_mem[idx] = data;
    end else begin
      if ((mode == MK_SWROM || mode == MK_MMU) && ea >= IO_LO && ea < HI_LO) return r;
      idx = shadow_index(ea);
      if (idx < 0) return r;
      // ff00..ffef is not compared on the flat-high machine, but still recorded
      if (shadow_mem.exists(idx) && shadow_mem[idx] != data &&
          !(mode == MK_FLAT_HI && ea >= HI_LO && ea < VEC_LO)) begin
        r.data_mismatch = 1'b1;
        r.expected_data = shadow_mem[idx];
      end
      shadow_mem[idx] = data;
    end
    return r;
  endfunction

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      mode       = MK_FLAT;
      type_mask  = '0;
      bank_latch = BANK_RESET;
      mmu_en     = 1'b0;
      foreach (mmu_map[i]) mmu_map[i] = PAGE_RESET;
      shadow_mem.delete();
      result_q.delete();
      errors     = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (result_q.size() == 0) begin
          $error("result word with no access outstanding");
          errors++;
        end else begin
          want = result_q.pop_front();
          check_field("rnw_error", {7'b0, want.rnw_error}, {7'b0, rnw_error});
          check_field("data_mismatch", {7'b0, want.data_mismatch}, {7'b0, data_mismatch});
          check_field("expected_data", want.expected_data, expected_data);
          check_field("write_ignored", {7'b0, want.write_ignored}, {7'b0, write_ignored});
        end
      end
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_MACHINE: mode = machine_t'(cfg_data[1:0]);
          CFG_MASK:    type_mask = cfg_data;
          CFG_BANK:    bank_latch = cfg_data[4:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        result_q.push_back(predict_access(req_type, address_known, address, bus_data,
                                          rnw_pin, access_type));
    end
    pending = result_q.size();
  end

endmodule

@@ tb/bus_shadow_memory_checker_top_tb.sv @@
`timescale 1ns / 100ps
module bus_shadow_memory_checker_top_tb;
  import bsmc_pkg::*;

  // reset sweep of the whole store runs with in_ready low
  localparam int WATCHDOG_LIMIT = 3 * WORDS;
  localparam int DRAIN_CYCLES   = 8;
  localparam int PHASES         = 9;

  localparam logic [15:0] IO_REGS [7] = '{MMU_ON_ADDR, MMU_OFF_ADDR, MMU_PAGE_ADDR,
                                          MMU_PAGE_ADDR + 16'd1, MMU_PAGE_ADDR + 16'd2,
                                          MMU_PAGE_LAST, ROM_LATCH_ADDR};

  typedef struct packed {
    logic        req;
    logic        known;
    logic [15:0] addr;
    logic [7:0]  data;
    logic        pin;
    logic [2:0]  kind;
  } bus_word_t;

  machine_t   ph_kind  [PHASES] = '{MK_FLAT, MK_FLAT_HI, MK_SWROM, MK_MMU, MK_SWROM,
                                    MK_FLAT, MK_MMU, MK_SWROM, MK_MMU};
  logic [7:0] ph_mask  [PHASES] = '{8'hff, 8'hff, 8'hff, 8'hff, 8'h5a,
                                    8'h00, 8'hff, 8'hff, 8'ha5};
  logic [4:0] ph_bank  [PHASES] = '{5'd16, 5'd0, 5'd16, 5'd5, 5'd0,
                                    5'd16, 5'd9, 5'd15, 5'd16};
  int         ph_items [PHASES] = '{170, 170, 200, 180, 170, 30, 170, 200, 160};

  logic        clk           = 1'b0;
  logic        rst           = 1'b1;
  logic        in_valid      = 1'b0;
  logic        in_ready;
  logic        req_type      = 1'b0;
  logic        address_known = 1'b0;
  logic [15:0] address       = '0;
  logic [7:0]  bus_data      = '0;
  logic        rnw_pin       = 1'b1;
  logic [2:0]  access_type   = '0;
  logic        out_valid;
  logic        out_ready     = 1'b0;
  logic        rnw_error;
  logic        data_mismatch;
  logic [7:0]  expected_data;
  logic        write_ignored;
  logic        cfg_wr_en     = 1'b0;
  logic [1:0]  cfg_index     = '0;
  logic [7:0]  cfg_data      = '0;

  int errors;
  int pending;
  int idle_pct     = 37;
  int stall_cycles = 0;

  bus_shadow_memory_checker_top u_top (.*);
  bsmc_shadow_checker u_check (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) out_ready <= ($urandom_range(0, 99) >= idle_pct);

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("bus_shadow_memory_checker_top_tb: FAIL");
      $finish;
    end
  end

  function automatic bus_word_t bus_word(input logic req, input logic known,
                                         input logic [15:0] addr, input logic [7:0] data,
                                         input logic pin, input logic [2:0] kind);
    bus_word_t w;
    w = '{req, known, addr, data, pin, kind};
    return w;
  endfunction

  function automatic bus_word_t random_word();
    bus_word_t w;
    int        pick;
    w.req   = 1'($urandom_range(0, 1));
    w.known = ($urandom_range(0, 99) >= 6);
    w.kind  = 3'($urandom_range(0, 7));
    w.data  = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 3)) : 8'($urandom);
    pick    = $urandom_range(0, 99);
    if (pick < 50) begin
      // small working set at both ends of each window so reads hit earlier writes
      w.addr = {2'($urandom_range(0, 3)),
                ($urandom_range(0, 1) != 0) ? 14'($urandom_range(0, 7))
                                            : 14'h3ff8 + 14'($urandom_range(0, 7))};
    end else if (pick < 62) begin
      w.addr = IO_REGS[$urandom_range(0, 6)];
      w.req  = ($urandom_range(0, 99) < 80) ? REQ_WRITE : REQ_READ;
      if ($urandom_range(0, 1) != 0) w.data = {3'b0, 1'($urandom), 2'b0, 2'($urandom)};
    end else if (pick < 72) begin
      w.addr = IO_LO + 16'($urandom_range(0, 16'h3ff));
    end else if (pick < 80) begin
      w.addr = ROM_LO + 16'($urandom_range(0, 7));
    end else begin
      w.addr = 16'($urandom);
    end
    w.pin = ($urandom_range(0, 99) < 8) ? w.req : !w.req;
    return w;
  endfunction

  // called at a falling edge; returns at the falling edge after the word is taken
  task automatic send_word(input bus_word_t w);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    req_type      <= w.req;
    address_known <= w.known;
    address       <= w.addr;
    bus_data      <= w.data;
    rnw_pin       <= w.pin;
    access_type   <= w.kind;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic rd(input logic [15:0] addr, input logic [7:0] data);
    send_word(bus_word(REQ_READ, 1'b1, addr, data, 1'b1, 3'($urandom_range(0, 6))));
  endtask

  task automatic wr(input logic [15:0] addr, input logic [7:0] data);
    send_word(bus_word(REQ_WRITE, 1'b1, addr, data, 1'b0, 3'($urandom_range(0, 6))));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_config(input machine_t kind, input logic [7:0] mask,
                              input logic [4:0] bank);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_MACHINE;
    cfg_data  <= {6'b0, kind};
    @(negedge clk);
    cfg_index <= CFG_MASK;
    cfg_data  <= mask;
    @(negedge clk);
    cfg_index <= CFG_BANK;
    cfg_data  <= {3'b0, bank};
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings: no type modelled
    wr(16'h1234, 8'haa);
    rd(16'h1234, 8'h55);
    send_word(bus_word(REQ_READ, 1'b1, 16'h1234, 8'h00, 1'b0, 3'd0));

    wait_drained();
    write_config(MK_FLAT, 8'h7f, BANK_RESET);
    wr(16'h0000, 8'h00);
    rd(16'h0000, 8'hff);
    send_word(bus_word(REQ_WRITE, 1'b1, 16'hffff, 8'hff, 1'b1, 3'd0));
    rd(16'hffff, 8'h00);
    send_word(bus_word(REQ_READ, 1'b0, 16'hffff, 8'h5a, 1'b1, 3'd0));
    send_word(bus_word(REQ_READ, 1'b1, 16'h0000, 8'h33, 1'b1, 3'd7));
    rd(16'h0000, 8'h34);

    wait_drained();
    write_config(MK_FLAT_HI, 8'hff, 5'd0);
    wr(16'hff80, 8'h11);
    rd(16'hff80, 8'h22);
    wr(16'hfff0, 8'h55);
    rd(16'hfff0, 8'h44);

    // sideways ROM: the bank starts out of range, then the latch selects bank 3
    wait_drained();
    write_config(MK_SWROM, 8'hff, BANK_RESET);
    wr(16'h8000, 8'h77);
    rd(16'h8000, 8'h01);
    wr(ROM_LATCH_ADDR, 8'hf3);
    rd(16'h8123, 8'h05);
    rd(16'h8123, 8'h06);
    rd(16'hfd00, 8'h00);
    wr(16'hff00, 8'h12);

    // MMU: window 0 maps to the same block before and after enabling
    wait_drained();
    write_config(MK_MMU, 8'hff, BANK_RESET);
    rd(16'h0000, 8'h21);
    wr(MMU_PAGE_ADDR, 8'h80);
    wr(MMU_ON_ADDR, 8'h10);
    rd(16'h0000, 8'h22);
    wr(MMU_OFF_ADDR, 8'h10);

    foreach (ph_kind[p]) begin
      wait_drained();
      write_config(ph_kind[p], ph_mask[p], ph_bank[p]);
      idle_pct = (p == 3) ? 0 : 37;
      repeat (ph_items[p]) send_word(random_word());
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0) begin
      $display("bus_shadow_memory_checker_top_tb: PASS");
    end else begin
      $display("bus_shadow_memory_checker_top_tb: FAIL");
    end
    $finish;
  end

endmodule
